// ----- rtl/core/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and shared types for the hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int FIFO_DEPTH  = 4;

  typedef logic [31:0] word_t;
  typedef logic [5:0]  blk_addr_t;

  // Command from the front end to the compression engine.
  typedef struct packed {
    logic     is_final;  // this block ends a message: emit digest, reinit
  } blk_cmd_t;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic word_t rotr(input word_t x, input int unsigned k);
    rotr = (x >> k) | (x << (32 - k));
  endfunction

endpackage

// ----- rtl/core/sha_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Takes bytes, keeps the length, writes padding and pushes 32-bit message
// words plus block commands toward the compression engine.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 has_byte,
  input  logic [7:0]           data_byte,
  input  logic                 is_last,
  // word stream to the engine
  output logic                 wvalid,
  output sha_pkg::word_t       wdata,
  output sha_pkg::blk_cmd_t    wcmd,     // meaningful on the last word of a block
  output logic                 wend,     // last word of a block
  input  logic                 wready
);
  import sha_pkg::*;

  typedef enum logic [1:0] {S_BYTES, S_PAD, S_LEN} state_t;

  state_t      state;
  logic [60:0] msg_len;
  logic [5:0]  fill;        // bytes placed in the current block
  logic [23:0] acc;         // upper bytes of the word being built
  logic        out_valid;
  word_t       out_word;
  logic        out_end;
  logic        out_final;
  logic [63:0] bit_len;
  logic        pad_first;   // next padding byte is the 0x80 marker

  logic        byte_go;
  logic [7:0]  byte_val;
  logic        put;
  logic        can_put;

  assign can_put = !out_valid || wready;
  assign full    = (state != S_BYTES) || !can_put;
  assign bit_len = {msg_len, 3'b000};

  // which byte goes into the block this cycle
  always_comb begin
    byte_go  = 1'b0;
    byte_val = 8'h00;
    unique case (state)
      S_BYTES: begin
        byte_go  = push && !full && has_byte;
        byte_val = data_byte;
      end
      S_PAD: begin
        byte_go  = can_put;
        byte_val = pad_first ? PAD_BYTE : 8'h00;
      end
      S_LEN: begin
        // offsets 56..63 carry length bytes, most significant first
        byte_go  = can_put;
        byte_val = bit_len[{~fill[2:0], 3'b111} -: 8];
      end
      default: ;
    endcase
  end

  assign put = byte_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BYTES;
      msg_len   <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      pad_first <= 1'b0;
    end else begin
      if (out_valid && wready) out_valid <= 1'b0;
      if (put) begin
        fill <= fill + 6'd1;
        if (fill[1:0] == 2'd3) begin
          out_valid <= 1'b1;
          out_word  <= {acc, byte_val};
          out_end   <= (fill == 6'd63);
          out_final <= (state == S_LEN) && (fill == 6'd63);
        end else begin
          acc <= {acc[15:0], byte_val};
        end
      end
      unique case (state)
        S_BYTES: begin
          if (push && !full) begin
            if (has_byte) msg_len <= msg_len + 61'd1;
            if (is_last) begin
              state     <= S_PAD;
              pad_first <= 1'b1;
            end
          end
        end
        S_PAD: begin
          // the pad marker byte goes first, then zeros to offset 56
          if (put) begin
            pad_first <= 1'b0;
            if (fill + 6'd1 == 6'd56) state <= S_LEN;
          end
        end
        S_LEN: begin
          if (put && fill == 6'd63) begin
            state   <= S_BYTES;
            msg_len <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign wvalid = out_valid;
  assign wdata  = out_word;
  assign wend   = out_end;
  assign wcmd.is_final = out_final;

endmodule

// ----- rtl/core/sha_fifo.sv -----
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short FIFO of message words between the front end and the engine.
// ----------------------------------------------------------------------------
module sha_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [33:0]          in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [33:0]          out_data
);
  localparam int AW = $clog2(DEPTH);

  logic [33:0] mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic do_w, do_r;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rptr];
  assign do_w = in_valid && in_ready;
  assign do_r = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_w) mem[wptr] <= in_data;
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_w) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (do_r) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(do_w) - (AW+1)'(do_r);
    end
  end

endmodule

// ----- rtl/core/sha_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Collects 16 words, runs 64 rounds one per cycle with a rolling 16-word
// schedule, updates the chaining state; final blocks emit four digest parts.
// ----------------------------------------------------------------------------
module sha_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wvalid,
  output logic                 wready,
  input  sha_pkg::word_t       wdata,
  input  logic                 wend,
  input  sha_pkg::blk_cmd_t    wcmd,
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          digest_part,
  output logic [1:0]           part_index,
  output logic                 is_last_part
);
  import sha_pkg::*;

  typedef enum logic [1:0] {E_LOAD, E_ROUND, E_ADD, E_OUT} state_t;

  state_t     state;
  word_t      h [8];
  word_t      v [8];
  word_t      w [16];
  logic [5:0] rnd;
  logic       final_blk;
  logic [1:0] part;

  word_t s0, s1, w_new, t1, t2, e, a, wr;

  assign wready = (state == E_LOAD);

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
    wr = w[0];
    e = v[4];
    a = v[0];
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[rnd] + wr;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_LOAD;
      rnd   <= '0;
      part  <= '0;
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
    end else begin
      unique case (state)
        E_LOAD: begin
          if (wvalid) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= wdata;
            if (wend) begin
              final_blk <= wcmd.is_final;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              rnd   <= '0;
              state <= E_ROUND;
            end
          end
        end
        E_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= E_ADD;
        end
        E_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          part  <= '0;
          state <= final_blk ? E_OUT : E_LOAD;
        end
        E_OUT: begin
          if (pop) begin
            part <= part + 2'd1;
            if (part == 2'd3) begin
              for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
              state <= E_LOAD;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign empty        = (state != E_OUT);
  assign digest_part  = {h[{part, 1'b0}], h[{part, 1'b1}]};
  assign part_index   = part;
  assign is_last_part = (part == 2'd3);

endmodule

// ----- rtl/core/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 streaming hasher
// Byte-serial SHA-256 with padding and a four-part 64-bit digest output.
// ----------------------------------------------------------------------------
//  Channel | Handshake     | Payload
//  --------+---------------+-----------------------------------------------
//  input   | push / full   | has_byte, data_byte, is_last
//  result  | empty / pop   | digest_part, part_index, is_last_part
//
//  A byte transfer is accepted while the word queue has room; after the
//  16th word of a block the engine runs the rounds and the chaining add
//  and takes no words meanwhile, so input stalls once the queue fills.
//  After is_last, full stays high while the front end writes the 0x80
//  marker, zeros and the 64-bit length, 9 to 72 bytes at one per cycle
//  while the queue has room. rst is synchronous; parts stay on the ports
//  until popped, and a result stall stalls the engine, queue, then input.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_part,
  output logic [1:0]  part_index,
  output logic        is_last_part
);
  import sha_pkg::*;

  logic            fw_valid, fw_ready, fw_end;
  word_t           fw_data;
  blk_cmd_t        fw_cmd;
  logic            ew_valid, ew_ready;
  logic [33:0]     q_out;
  blk_cmd_t        e_cmd;

  // front end: byte packing, length count and padding
  sha_front u_front (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .has_byte(has_byte), .data_byte(data_byte), .is_last(is_last),
    .wvalid(fw_valid), .wdata(fw_data), .wcmd(fw_cmd), .wend(fw_end),
    .wready(fw_ready)
  );

  // queue entry: {final block, end of block, word}
  sha_fifo #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(fw_valid), .in_ready(fw_ready),
    .in_data({fw_cmd.is_final, fw_end, fw_data}),
    .out_valid(ew_valid), .out_ready(ew_ready),
    .out_data(q_out)
  );

  assign e_cmd.is_final = q_out[33];

  sha_engine u_engine (
    .clk(clk), .rst(rst),
    .wvalid(ew_valid), .wready(ew_ready),
    .wdata(q_out[31:0]), .wend(q_out[32]), .wcmd(e_cmd),
    .empty(empty), .pop(pop),
    .digest_part(digest_part), .part_index(part_index),
    .is_last_part(is_last_part)
  );

  // padding follows every accepted last item, so input is held off
  a_pad_full: assert property (@(posedge clk) disable iff (rst)
    (push && !full && is_last) |=> full)
    else $error("input accepted during padding");
  a_part_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_last_part) |-> (part_index == 2'd3))
    else $error("last part flag on wrong quarter");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(digest_part) && $stable(part_index)))
    else $error("waiting digest part changed");

endmodule

// ----- dv/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels of the hasher, hashes accepted bytes on its own and
// compares each popped digest part with the oldest predicted one.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        has_byte,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] digest_part,
  input  logic [1:0]  part_index,
  input  logic        is_last_part,
  output int          fail_count,
  output int          parts_pending,
  output int          digests_seen
);

  typedef struct {
    logic [63:0] digest;
    logic [1:0]  idx;
    logic        last;
  } part_t;

  localparam logic [31:0] H_START [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [60:0] msg_len;
  part_t       digest_q [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic run_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, e, a;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    v = chain;
    for (int i = 0; i < 64; i++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
         + K_TAB[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      chain[i] += v[i];
  endtask

  task automatic absorb(input logic [7:0] b);
    blk[fill] = b;
    fill++;
    if (fill == 0)
      run_block();
  endtask

  task automatic restart();
    chain = H_START;
    fill = '0;
    msg_len = '0;
  endtask

  // Pad, emit four expected parts, reinit.
  task automatic finish_message();
    logic [63:0] bit_len;
    part_t p;
    bit_len = {msg_len, 3'b000};
    absorb(8'h80);
    while (fill != 6'd56)
      absorb(8'h00);
    for (int k = 0; k < 8; k++)
      absorb(bit_len[63 - 8*k -: 8]);
    for (int k = 0; k < 4; k++) begin
      p.digest = {chain[2*k], chain[2*k+1]};
      p.idx = k[1:0];
      p.last = (k == 3);
      digest_q.push_back(p);
    end
    restart();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart();
      digest_q.delete();
    end else begin
      if (pop && !empty) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest transfer: part %0d %h", part_index, digest_part);
          fail_count++;
        end else begin
          part_t exp_p;
          exp_p = digest_q.pop_front();
          if (digest_part !== exp_p.digest) begin
            $error("digest_part exp %h got %h", exp_p.digest, digest_part);
            fail_count++;
          end
          if (part_index !== exp_p.idx) begin
            $error("part_index exp %0d got %0d", exp_p.idx, part_index);
            fail_count++;
          end
          if (is_last_part !== exp_p.last) begin
            $error("is_last_part exp %0d got %0d", exp_p.last, is_last_part);
            fail_count++;
          end
          if (exp_p.last)
            digests_seen++;
        end
      end
      if (push && !full) begin
        if (has_byte) begin
          absorb(data_byte);
          msg_len++;
        end
        if (is_last)
          finish_message();
      end
    end
    parts_pending = digest_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Drives byte messages of many lengths under random flow control; the
// checker beside the block predicts and compares every digest part.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        has_byte = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] digest_part;
  logic [1:0]  part_index;
  logic        is_last_part;

  int fail_count, parts_pending, digests_seen;
  int tx_idle = 0;     // percent of cycles the sender skips
  int rx_idle = 0;     // percent of cycles the receiver skips
  bit rx_hold = 1'b0;  // long result-side stall
  int byte_xfers = 0;
  int cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha256_stream_hasher DUT (
    .clk, .rst, .push, .full, .has_byte, .data_byte, .is_last,
    .empty, .pop, .digest_part, .part_index, .is_last_part
  );

  sha256_digest_checker u_checker (
    .clk, .rst, .push, .full, .has_byte, .data_byte, .is_last,
    .empty, .pop, .digest_part, .part_index, .is_last_part,
    .fail_count, .parts_pending, .digests_seen
  );

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Result side: random pop, unless a long hold is in force.
  always @(posedge clk) begin
    if (rst)
      pop <= 1'b0;
    else
      pop <= !rx_hold && ($urandom_range(99) >= rx_idle);
  end

  // One input transfer. Signals change only at a rising edge; full is
  // checked at the falling edge so the accepting edge is known. push stays
  // high after the transfer; the next item, an idle cycle or a drain
  // pause replaces it at that same edge.
  task automatic send_item(input bit hb, input logic [7:0] db, input bit last_flag);
    while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    has_byte <= hb;
    data_byte <= db;
    is_last <= last_flag;
    do @(negedge clk); while (full);
    @(posedge clk);
    if (hb)
      byte_xfers++;
  endtask

  // Random-content message; the closing transfer may or may not carry a byte.
  task automatic send_message(input int len);
    bit tail_byte;
    tail_byte = (len > 0) && $urandom_range(1);
    for (int i = 0; i < len - tail_byte; i++) begin
      if ($urandom_range(15) == 0)
        send_item(1'b0, 8'($urandom), 1'b0);  // bubble, no byte
      send_item(1'b1, 8'($urandom), 1'b0);
    end
    send_item(tail_byte, 8'($urandom), 1'b1);
  endtask

  // Called at a rising edge; returns at a rising edge.
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (parts_pending != 0);
    @(posedge clk);
  endtask

  // Mostly short messages, with the padding boundaries hit often.
  function automatic int pick_len();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return $urandom_range(54, 57);
      1: return $urandom_range(62, 65);
      2: return $urandom_range(118, 121);
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty message, lone extreme bytes, bubbles, bare last.
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'h00, 1'b1);
    send_item(1'b1, 8'hff, 1'b1);
    send_item(1'b0, 8'hff, 1'b0);
    send_item(1'b1, 8'h55, 1'b0);
    send_item(1'b0, 8'haa, 1'b0);
    send_item(1'b1, 8'haa, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b1, 8'h01, 1'b0);
    send_item(1'b1, 8'h80, 1'b1);
    send_item(1'b0, 8'h00, 1'b1);
    wait_drained();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 30 : (ph == 1) ? 52 : 0;
      rx_idle = (ph == 0) ? 52 : (ph == 1) ? 30 : 0;
      if (ph == 0) begin
        // Receiver stalls long while a multi-block message streams in.
        fork
          begin
            @(negedge clk) rx_hold = 1'b1;
            repeat (600) @(posedge clk);
            @(negedge clk) rx_hold = 1'b0;
          end
        join_none
        send_message(3);
        send_message(130);
        send_message(0);
        sent += 136;
      end
      while (sent < 130 * (ph + 1)) begin
        int len;
        len = pick_len();
        send_message(len);
        sent += len + 1;
      end
      // Sender stops until every digest is out.
      wait_drained();
    end

    repeat (200) @(posedge clk);

    $display("%0d message bytes hashed into %0d digests, idle mixes 30/52, 52/30, 0/0,",
             byte_xfers, digests_seen);
    $display("with a long result stall and drain pauses");
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sha_pkg.sv
rtl/core/sha_front.sv
rtl/core/sha_fifo.sv
rtl/core/sha_engine.sv
rtl/core/sha256_stream_hasher.sv
dv/sha256_digest_checker.sv
dv/tb_top.sv
